/* hdl/ptbv_pkg.sv */
// ---------------------------------------------------------------------------
// ptbv_pkg
// shared types, widths, constants and the cordic angle table for the
// pose to body velocity block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptbv_pkg;

  // cordic iteration count, 8 to 24
  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;
  localparam int TAB_IDX_W    = $clog2(TAB_LEN);

  // quotient bits produced by each divider lane, one per cycle
  localparam int DIV_STEPS = 32;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam int POS_W   = 32;
  localparam int QUAT_W  = 16;
  localparam int STAMP_W = 48;
  localparam int VEL_W   = 32;
  localparam int YAW_W   = 16;

  // shared multiplier and accumulators
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 26;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // cordic registers and heading cos/sin in q24
  localparam int CX_W = 36;
  localparam int CZ_W = 34;
  localparam int CS_W = 26;

  // divider numerator magnitude
  localparam int DIV_N_W = 56;

  localparam logic signed [CX_W-1:0]    INV_GAIN  = 36'sd652032874;
  localparam logic signed [MUL_B_W-1:0] VEL_SCALE = 26'sd1000000;
  localparam logic signed [MUL_B_W-1:0] YAW_SCALE = 26'sd6283185;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
    logic signed [QUAT_W-1:0] quat_w;
    logic [STAMP_W-1:0]       stamp_us;
  } in_item_t;

  typedef struct packed {
    logic [STAMP_W-1:0]      out_stamp_us;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] yaw_rate;
    logic                    time_error;
  } out_item_t;

  typedef enum logic [3:0] {
    MUL_WW, MUL_XX, MUL_YY, MUL_ZZ, MUL_XY, MUL_WZ,
    MUL_C_DX, MUL_S_DY, MUL_C_DY, MUL_S_DX,
    MUL_RX, MUL_RY, MUL_YAW
  } mul_sel_e;

  typedef enum logic [3:0] {
    ACC_NONE,
    ACC_A_LD, ACC_A_LDR, ACC_A_ADD, ACC_A_SUB,
    ACC_B_LD, ACC_B_LDR, ACC_B_ADD, ACC_B_SUB,
    ACC_N0, ACC_N1, ACC_N2
  } acc_op_e;

  typedef struct packed {
    logic                 load_in;
    mul_sel_e             mul_sel;
    acc_op_e              acc_op;
    logic                 cor_init_vec;
    logic                 cor_init_rot;
    logic                 cor_step;
    logic [TAB_IDX_W-1:0] step;
    logic                 cap_yaw;
    logic                 cap_cs;
    logic                 div_init;
    logic                 div_step;
    logic                 store_prev;
    logic                 out_load;
    logic                 out_err;
  } dp_cmd_t;

  typedef struct packed {
    logic stamp_zero;
    logic have_prev;
    logic time_bad;
  } dp_status_t;

endpackage

`default_nettype wire

/* hdl/ptbv_div_lane.sv */
// ---------------------------------------------------------------------------
// ptbv_div_lane
// restoring divider lane: |num| / dt rounded to nearest, saturated to 32 bits
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptbv_div_lane (
  input  wire logic                                  clk_i,
  input  wire logic                                  load_i,
  input  wire logic signed [ptbv_pkg::PROD_W-1:0]    num_i,
  input  wire logic                                  init_i,
  input  wire logic                                  step_i,
  input  wire logic [ptbv_pkg::STAMP_W-1:0]          dt_i,
  output logic signed [ptbv_pkg::VEL_W-1:0]          res_o
);
  import ptbv_pkg::*;

  localparam int HI_W = DIV_N_W - DIV_STEPS;

  logic signed [PROD_W-1:0] num_q;
  logic                     neg_q, ovf_q;
  logic [STAMP_W-1:0]       rem_q;
  logic [DIV_STEPS-1:0]     quo_q;

  logic [PROD_W-1:0]  mag;
  logic [DIV_N_W-1:0] rounded;
  logic [STAMP_W-1:0] hi;
  logic [STAMP_W:0]   trial;
  logic               ge;

  always_comb begin
    mag     = num_q[PROD_W-1] ? PROD_W'(-num_q) : PROD_W'(num_q);
    // add half the divisor for round to nearest
    rounded = mag[DIV_N_W-1:0] + DIV_N_W'(dt_i[STAMP_W-1:1]);
    hi      = STAMP_W'(rounded[DIV_N_W-1:DIV_STEPS]);
    trial   = {rem_q, quo_q[DIV_STEPS-1]};
    ge      = trial >= {1'b0, dt_i};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      num_q <= num_i;
    end
    if (init_i) begin
      neg_q <= num_q[PROD_W-1];
      ovf_q <= hi >= dt_i;
      rem_q <= hi;
      quo_q <= rounded[DIV_STEPS-1:0];
    end else if (step_i) begin
      rem_q <= ge ? STAMP_W'(trial - {1'b0, dt_i}) : trial[STAMP_W-1:0];
      quo_q <= {quo_q[DIV_STEPS-2:0], ge};
    end
  end

  // saturation to [-2^31, 2^31-1]
  always_comb begin
    if (neg_q) begin
      if (ovf_q || quo_q > {1'b1, {(DIV_STEPS-1){1'b0}}}) begin
        res_o = {1'b1, {(VEL_W-1){1'b0}}};
      end else begin
        res_o = VEL_W'(-quo_q);
      end
    end else begin
      if (ovf_q || quo_q[DIV_STEPS-1]) begin
        res_o = {1'b0, {(VEL_W-1){1'b1}}};
      end else begin
        res_o = VEL_W'(quo_q);
      end
    end
  end

  logic unused_hi;
  assign unused_hi = ^{mag[PROD_W-1:DIV_N_W], HI_W[0]};

endmodule

`default_nettype wire

/* hdl/ptbv_dp.sv */
// ---------------------------------------------------------------------------
// ptbv_dp
// datapath: shared multiplier, accumulators, shared cordic, divider lanes,
// previous pose and output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptbv_dp (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ptbv_pkg::dp_cmd_t    cmd_i,
  input  wire ptbv_pkg::in_item_t   in_item_i,
  output ptbv_pkg::dp_status_t      st_o,
  output ptbv_pkg::out_item_t       out_item_o
);
  import ptbv_pkg::*;

  localparam logic signed [CZ_W-1:0] QUARTER = 34'sd1073741824;
  localparam logic signed [CZ_W-1:0] HALF    = 34'sd2147483648;
  localparam logic signed [PROD_W-1:0] RND24 = PROD_W'(64'sd8388608);

  in_item_t in_q;

  // previous pose
  logic                      have_prev_q;
  logic signed [POS_W-1:0]   prev_x_q, prev_y_q;
  logic [YAW_W-1:0]          prev_yaw_q;
  logic [STAMP_W-1:0]        prev_stamp_q;

  logic [YAW_W-1:0]          yaw_q;
  logic signed [CS_W-1:0]    c_q, s_q;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod, p_q;
  acc_op_e                   op_q;
  logic signed [PROD_W-1:0]  acc_a_q, acc_b_q;

  logic signed [POS_W:0]     dx, dy;
  logic signed [YAW_W-1:0]   dyaw;
  logic [STAMP_W-1:0]        dt;

  // cordic
  logic signed [CX_W-1:0]    cx_q, cy_q;
  logic signed [CZ_W-1:0]    cz_q;
  logic                      vec_q, rneg_q, qzero_q;
  logic signed [CX_W-1:0]    xs, ys;
  logic signed [CZ_W-1:0]    at;
  logic                      dpos;
  logic signed [CZ_W-1:0]    zr;
  logic signed [CX_W-1:0]    xf, yf, cr, sr;
  logic [31:0]               zround;

  logic signed [VEL_W-1:0]   res0, res1, res2;
  out_item_t                 out_q;

  assign dx   = (POS_W+1)'(in_q.pos_x) - (POS_W+1)'(prev_x_q);
  assign dy   = (POS_W+1)'(in_q.pos_y) - (POS_W+1)'(prev_y_q);
  assign dyaw = yaw_q - prev_yaw_q;
  assign dt   = in_q.stamp_us - prev_stamp_q;

  assign st_o.stamp_zero = in_q.stamp_us == '0;
  assign st_o.have_prev  = have_prev_q;
  assign st_o.time_bad   = in_q.stamp_us <= prev_stamp_q;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_WW:   begin mul_a = MUL_A_W'(in_q.quat_w); mul_b = MUL_B_W'(in_q.quat_w); end
      MUL_XX:   begin mul_a = MUL_A_W'(in_q.quat_x); mul_b = MUL_B_W'(in_q.quat_x); end
      MUL_YY:   begin mul_a = MUL_A_W'(in_q.quat_y); mul_b = MUL_B_W'(in_q.quat_y); end
      MUL_ZZ:   begin mul_a = MUL_A_W'(in_q.quat_z); mul_b = MUL_B_W'(in_q.quat_z); end
      MUL_XY:   begin mul_a = MUL_A_W'(in_q.quat_x); mul_b = MUL_B_W'(in_q.quat_y); end
      MUL_WZ:   begin mul_a = MUL_A_W'(in_q.quat_w); mul_b = MUL_B_W'(in_q.quat_z); end
      MUL_C_DX: begin mul_a = MUL_A_W'(dx); mul_b = c_q; end
      MUL_S_DY: begin mul_a = MUL_A_W'(dy); mul_b = s_q; end
      MUL_C_DY: begin mul_a = MUL_A_W'(dy); mul_b = c_q; end
      MUL_S_DX: begin mul_a = MUL_A_W'(dx); mul_b = s_q; end
      MUL_RX:   begin mul_a = acc_a_q[MUL_A_W+23:24]; mul_b = VEL_SCALE; end
      MUL_RY:   begin mul_a = acc_b_q[MUL_A_W+23:24]; mul_b = VEL_SCALE; end
      MUL_YAW:  begin mul_a = MUL_A_W'(dyaw); mul_b = YAW_SCALE; end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod = mul_a * mul_b;

  // cordic step, shared by vectoring and rotation
  always_comb begin
    xs   = cx_q >>> cmd_i.step;
    ys   = cy_q >>> cmd_i.step;
    at   = CZ_W'(ATAN_TAB[cmd_i.step]);
    dpos = vec_q ? cy_q[CX_W-1] : !cz_q[CZ_W-1];
    // fold the heading into [-pi/2, pi/2]
    zr   = CZ_W'($signed({prev_yaw_q, 16'h0000}));
    xf   = rneg_q ? -cx_q : cx_q;
    yf   = rneg_q ? -cy_q : cy_q;
    cr   = xf + 36'sd32;
    sr   = yf + 36'sd32;
    zround = cz_q[31:0] + 32'h0000_8000;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q         <= ACC_NONE;
      have_prev_q  <= 1'b0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      prev_yaw_q   <= '0;
      prev_stamp_q <= '0;
    end else begin
      op_q <= cmd_i.acc_op;
      if (cmd_i.store_prev) begin
        have_prev_q  <= 1'b1;
        prev_x_q     <= in_q.pos_x;
        prev_y_q     <= in_q.pos_y;
        prev_yaw_q   <= yaw_q;
        prev_stamp_q <= in_q.stamp_us;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_item_i;
    end
    p_q <= prod;
    case (op_q)
      ACC_A_LD:  acc_a_q <= p_q;
      ACC_A_LDR: acc_a_q <= p_q + RND24;
      ACC_A_ADD: acc_a_q <= acc_a_q + p_q;
      ACC_A_SUB: acc_a_q <= acc_a_q - p_q;
      ACC_B_LD:  acc_b_q <= p_q;
      ACC_B_LDR: acc_b_q <= p_q + RND24;
      ACC_B_ADD: acc_b_q <= acc_b_q + p_q;
      ACC_B_SUB: acc_b_q <= acc_b_q - p_q;
      default:   ;
    endcase

    if (cmd_i.cor_init_vec) begin
      vec_q   <= 1'b1;
      qzero_q <= (acc_a_q == '0) && (acc_b_q == '0);
      if (acc_a_q[PROD_W-1]) begin
        cx_q <= -acc_a_q[CX_W-1:0];
        cy_q <= -{acc_b_q[CX_W-2:0], 1'b0};
        cz_q <= HALF;
      end else begin
        cx_q <= acc_a_q[CX_W-1:0];
        cy_q <= {acc_b_q[CX_W-2:0], 1'b0};
        cz_q <= '0;
      end
    end else if (cmd_i.cor_init_rot) begin
      vec_q <= 1'b0;
      cx_q  <= INV_GAIN;
      cy_q  <= '0;
      if (zr > QUARTER) begin
        cz_q   <= zr - HALF;
        rneg_q <= 1'b1;
      end else if (zr < -QUARTER) begin
        cz_q   <= zr + HALF;
        rneg_q <= 1'b1;
      end else begin
        cz_q   <= zr;
        rneg_q <= 1'b0;
      end
    end else if (cmd_i.cor_step) begin
      if (dpos) begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - at;
      end else begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + at;
      end
    end

    if (cmd_i.cap_yaw) begin
      yaw_q <= qzero_q ? '0 : zround[31:16];
    end
    if (cmd_i.cap_cs) begin
      c_q <= cr[CS_W+5:6];
      s_q <= sr[CS_W+5:6];
    end

    if (cmd_i.out_load) begin
      out_q.out_stamp_us <= in_q.stamp_us;
      out_q.vel_x        <= cmd_i.out_err ? '0 : res0;
      out_q.vel_y        <= cmd_i.out_err ? '0 : res1;
      out_q.yaw_rate     <= cmd_i.out_err ? '0 : res2;
      out_q.time_error   <= cmd_i.out_err;
    end
  end

  ptbv_div_lane u_lane_vx (
    .clk_i  (clk_i),
    .load_i (op_q == ACC_N0),
    .num_i  (p_q),
    .init_i (cmd_i.div_init),
    .step_i (cmd_i.div_step),
    .dt_i   (dt),
    .res_o  (res0)
  );

  ptbv_div_lane u_lane_vy (
    .clk_i  (clk_i),
    .load_i (op_q == ACC_N1),
    .num_i  (p_q),
    .init_i (cmd_i.div_init),
    .step_i (cmd_i.div_step),
    .dt_i   (dt),
    .res_o  (res1)
  );

  ptbv_div_lane u_lane_yr (
    .clk_i  (clk_i),
    .load_i (op_q == ACC_N2),
    .num_i  (p_q),
    .init_i (cmd_i.div_init),
    .step_i (cmd_i.div_step),
    .dt_i   (dt),
    .res_o  (res2)
  );

  assign out_item_o = out_q;

endmodule

`default_nettype wire

/* hdl/ptbv_ctrl.sv */
// ---------------------------------------------------------------------------
// ptbv_ctrl
// sequencer: steps the datapath through yaw, heading, rotation and division
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptbv_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  input  wire ptbv_pkg::dp_status_t  st_i,
  output ptbv_pkg::dp_cmd_t          cmd_o
);
  import ptbv_pkg::*;

  localparam int Q_MULS = 6;
  localparam int D_MULS = 4;
  localparam int N_MULS = 3;

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_QMUL, S_QWAIT, S_VINIT, S_VEC, S_YCAP, S_DEC,
    S_RINIT, S_ROT, S_CCAP, S_DMUL, S_DWAIT, S_NMUL, S_NWAIT,
    S_DINIT, S_DIV, S_OUT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE:  if (in_valid_i) state_q <= S_CHK;
        S_CHK:   state_q <= st_i.stamp_zero ? S_IDLE : S_QMUL;
        S_QMUL: begin
          if (cnt_q == CNT_W'(Q_MULS-1)) begin
            cnt_q   <= '0;
            state_q <= S_QWAIT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_QWAIT: state_q <= S_VINIT;
        S_VINIT: state_q <= S_VEC;
        S_VEC: begin
          if (cnt_q == CNT_W'(CORDIC_STEPS-1)) begin
            cnt_q   <= '0;
            state_q <= S_YCAP;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_YCAP:  state_q <= S_DEC;
        S_DEC: begin
          if (!st_i.have_prev) begin
            state_q <= S_IDLE;
          end else if (st_i.time_bad) begin
            state_q <= S_OUT;
          end else begin
            state_q <= S_RINIT;
          end
        end
        S_RINIT: state_q <= S_ROT;
        S_ROT: begin
          if (cnt_q == CNT_W'(CORDIC_STEPS-1)) begin
            cnt_q   <= '0;
            state_q <= S_CCAP;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_CCAP:  state_q <= S_DMUL;
        S_DMUL: begin
          if (cnt_q == CNT_W'(D_MULS-1)) begin
            cnt_q   <= '0;
            state_q <= S_DWAIT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DWAIT: state_q <= S_NMUL;
        S_NMUL: begin
          if (cnt_q == CNT_W'(N_MULS-1)) begin
            cnt_q   <= '0;
            state_q <= S_NWAIT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_NWAIT: state_q <= S_DINIT;
        S_DINIT: state_q <= S_DIV;
        S_DIV: begin
          if (cnt_q == CNT_W'(DIV_STEPS-1)) begin
            cnt_q   <= '0;
            state_q <= S_OUT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_WW;
    cmd_o.acc_op  = ACC_NONE;
    cmd_o.step    = TAB_IDX_W'(cnt_q);
    unique case (state_q)
      S_IDLE:  cmd_o.load_in = in_valid_i;
      S_QMUL: begin
        case (cnt_q)
          CNT_W'(0): begin cmd_o.mul_sel = MUL_WW; cmd_o.acc_op = ACC_A_LD;  end
          CNT_W'(1): begin cmd_o.mul_sel = MUL_XX; cmd_o.acc_op = ACC_A_ADD; end
          CNT_W'(2): begin cmd_o.mul_sel = MUL_YY; cmd_o.acc_op = ACC_A_SUB; end
          CNT_W'(3): begin cmd_o.mul_sel = MUL_ZZ; cmd_o.acc_op = ACC_A_SUB; end
          CNT_W'(4): begin cmd_o.mul_sel = MUL_XY; cmd_o.acc_op = ACC_B_LD;  end
          CNT_W'(5): begin cmd_o.mul_sel = MUL_WZ; cmd_o.acc_op = ACC_B_ADD; end
          default:   cmd_o.acc_op = ACC_NONE;
        endcase
      end
      S_VINIT: cmd_o.cor_init_vec = 1'b1;
      S_VEC:   cmd_o.cor_step     = 1'b1;
      S_YCAP:  cmd_o.cap_yaw      = 1'b1;
      S_DEC:   cmd_o.store_prev   = !st_i.have_prev;
      S_RINIT: cmd_o.cor_init_rot = 1'b1;
      S_ROT:   cmd_o.cor_step     = 1'b1;
      S_CCAP:  cmd_o.cap_cs       = 1'b1;
      S_DMUL: begin
        case (cnt_q)
          CNT_W'(0): begin cmd_o.mul_sel = MUL_C_DX; cmd_o.acc_op = ACC_A_LDR; end
          CNT_W'(1): begin cmd_o.mul_sel = MUL_S_DY; cmd_o.acc_op = ACC_A_ADD; end
          CNT_W'(2): begin cmd_o.mul_sel = MUL_C_DY; cmd_o.acc_op = ACC_B_LDR; end
          CNT_W'(3): begin cmd_o.mul_sel = MUL_S_DX; cmd_o.acc_op = ACC_B_SUB; end
          default:   cmd_o.acc_op = ACC_NONE;
        endcase
      end
      S_NMUL: begin
        case (cnt_q)
          CNT_W'(0): begin cmd_o.mul_sel = MUL_RX;  cmd_o.acc_op = ACC_N0; end
          CNT_W'(1): begin cmd_o.mul_sel = MUL_RY;  cmd_o.acc_op = ACC_N1; end
          CNT_W'(2): begin cmd_o.mul_sel = MUL_YAW; cmd_o.acc_op = ACC_N2; end
          default:   cmd_o.acc_op = ACC_NONE;
        endcase
      end
      S_DINIT: cmd_o.div_init = 1'b1;
      S_DIV:   cmd_o.div_step = 1'b1;
      S_OUT: begin
        cmd_o.out_load   = out_free;
        cmd_o.store_prev = out_free;
        cmd_o.out_err    = st_i.time_bad;
      end
      default: cmd_o.acc_op = ACC_NONE;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/pose_to_body_velocity_core.sv */
// ---------------------------------------------------------------------------
// pose_to_body_velocity_core
// planar odometry from successive timestamped poses: yaw from the quaternion,
// displacement rotated into the previous heading, divided by elapsed time
// ---------------------------------------------------------------------------
//
//  channel   handshake                  payload                 direction
//  -------   -------------------------  ----------------------  ---------
//  in        in_valid_i / in_stall_o    in_item_i  (in_item_t)  into block
//  out       out_valid_o / out_stall_i  out_item_o (out_item_t) out of block
//
//  one pose at a time; a full pose runs from accept to result through the
//  two cordic passes and the 32 step restoring dividers; a first or error
//  pose ends after the yaw pass
//  a zero stamp pose is dropped at the stamp check that follows accept
//  reset clears the sequencer, the output valid and the previous pose
//  a finished result waits in the output register while the next pose is
//  taken; out_stall_i only holds the sequencer when a second result is ready
//
`timescale 1ns / 1ps
`default_nettype none

module pose_to_body_velocity_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire ptbv_pkg::in_item_t   in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output ptbv_pkg::out_item_t       out_item_o
);
  import ptbv_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t    cmd;
  dp_status_t st;

  ptbv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // multiplier, cordic, divider lanes, previous pose, output register
  ptbv_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .st_o       (st),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire
